FILE: rtl/cvat_pkg.sv
// ----------------------------------------------------------------------------
// cvat_pkg: shared definitions of the chunked voxel address translator
// Sizes, field layout of the stream words, codes, state and control types.
// ----------------------------------------------------------------------------
package cvat_pkg;

  // Sizing of the design. CHUNK_WIDTH must be a power of two.
  localparam int CHUNK_WIDTH = 64;
  localparam int MAP_CELLS   = 4096;
  localparam int CHUNK_SLOTS = 1024;

  // Field widths.
  localparam int MODE_W     = 2;
  localparam int WORLD_W    = 24;
  localparam int CELL_W     = 12;
  localparam int SLOT_W     = 10;
  localparam int BASE_W     = 28;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = 28;
  localparam int CFG_MIN_W  = 18;
  localparam int CFG_SIZE_W = 13;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 3;

  // Input tdata layout, lowest field first.
  localparam int TD_WX_LSB   = 0;
  localparam int TD_WY_LSB   = TD_WX_LSB + WORLD_W;
  localparam int TD_WZ_LSB   = TD_WY_LSB + WORLD_W;
  localparam int TD_CELL_LSB = TD_WZ_LSB + WORLD_W;
  localparam int TD_OCC_LSB  = TD_CELL_LSB + CELL_W;
  localparam int TD_SLOT_LSB = TD_OCC_LSB + 1;
  localparam int TD_BASE_LSB = TD_SLOT_LSB + SLOT_W;
  localparam int IN_FIELDS_W = TD_BASE_LSB + BASE_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((IDX_W + 7) / 8) * 8;

  // Derived datapath widths.
  localparam int CHUNK_BITS    = $clog2(CHUNK_WIDTH);
  localparam int CHUNK_COORD_W = WORLD_W - CHUNK_BITS;
  localparam int OFS_W         = ((CHUNK_COORD_W > CFG_MIN_W) ? CHUNK_COORD_W : CFG_MIN_W) + 1;
  localparam int BOX_W         = CFG_SIZE_W;
  localparam int PY_W          = BOX_W + CFG_SIZE_W;
  localparam int SXY_W         = 2 * CFG_SIZE_W;
  localparam int PZ_W          = BOX_W + SXY_W;
  localparam int CELL_SUM_W    = PZ_W + 1;
  localparam int LOFF_W        = 3 * CHUNK_BITS;
  localparam int OCC_W         = 1 + SLOT_W;
  localparam int OCC_AW        = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
  localparam int BASE_AW       = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
  localparam int TBL_CMP_W     = 17;

  // Input modes.
  localparam logic [MODE_W-1:0] MODE_OCC_WRITE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BASE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRANSLATE  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_RESOLVED   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_WRITE_DONE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC1,
    ST_CALC2,
    ST_CALC3,
    ST_OCC,
    ST_BASE,
    ST_FINISH
  } cvat_state_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic calc1;
    logic calc2;
    logic calc3;
    logic occ;
    logic base;
    logic load_out;
  } cvat_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_translate;
  } cvat_stat_t;

endpackage

FILE: rtl/cvat_ram.sv
// ----------------------------------------------------------------------------
// cvat_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cvat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/cvat_ctrl.sv
// ----------------------------------------------------------------------------
// cvat_ctrl: sequencer of the address translator
// Runs the clearing pass, steps one item through the datapath, owns tvalid.
// ----------------------------------------------------------------------------
module cvat_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  cvat_pkg::cvat_stat_t st,
  output cvat_pkg::cvat_cmd_t  cmd
);

  cvat_pkg::cvat_state_t state, state_next;
  logic out_valid_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cvat_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cvat_pkg::ST_CLEAR: begin
        if (st.clr_last) state_next = cvat_pkg::ST_IDLE;
      end
      cvat_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = st.is_translate ? cvat_pkg::ST_CALC1 : cvat_pkg::ST_FINISH;
        end
      end
      cvat_pkg::ST_CALC1:  state_next = cvat_pkg::ST_CALC2;
      cvat_pkg::ST_CALC2:  state_next = cvat_pkg::ST_CALC3;
      cvat_pkg::ST_CALC3:  state_next = cvat_pkg::ST_OCC;
      cvat_pkg::ST_OCC:    state_next = cvat_pkg::ST_BASE;
      cvat_pkg::ST_BASE:   state_next = cvat_pkg::ST_FINISH;
      cvat_pkg::ST_FINISH: begin
        if (out_free) state_next = cvat_pkg::ST_IDLE;
      end
      default: state_next = cvat_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      cvat_pkg::ST_CLEAR:  cmd.clr_step = 1'b1;
      cvat_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      cvat_pkg::ST_CALC1:  cmd.calc1 = 1'b1;
      cvat_pkg::ST_CALC2:  cmd.calc2 = 1'b1;
      cvat_pkg::ST_CALC3:  cmd.calc3 = 1'b1;
      cvat_pkg::ST_OCC:    cmd.occ   = 1'b1;
      cvat_pkg::ST_BASE:   cmd.base  = 1'b1;
      cvat_pkg::ST_FINISH: cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  // The output slot fills on a load and drains on a downstream transfer.
  assign out_valid_next = cmd.load_out || (out_valid && !out_ready);

endmodule

FILE: rtl/cvat_dpath.sv
// ----------------------------------------------------------------------------
// cvat_dpath: datapath of the address translator
// Map registers, coordinate split, cell index, both tables and result.
// ----------------------------------------------------------------------------
module cvat_dpath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [cvat_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [cvat_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic [cvat_pkg::IN_TDATA_W-1:0]         in_data,
  input  logic [cvat_pkg::MODE_W-1:0]             in_mode,
  output logic [cvat_pkg::OUT_TDATA_W-1:0]        out_data,
  output logic [cvat_pkg::STATUS_W-1:0]           out_status,
  input  cvat_pkg::cvat_cmd_t                     cmd,
  output cvat_pkg::cvat_stat_t                    st
);

  // Map box registers.
  logic signed [cvat_pkg::CFG_MIN_W-1:0] min_x, min_y, min_z;
  logic [cvat_pkg::CFG_SIZE_W-1:0]       size_x, size_y, size_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x  <= '0;
      min_y  <= '0;
      min_z  <= '0;
      size_x <= cvat_pkg::CFG_SIZE_W'(1);
      size_y <= cvat_pkg::CFG_SIZE_W'(1);
      size_z <= cvat_pkg::CFG_SIZE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        cvat_pkg::CFG_MIN_X:  min_x  <= cfg_data[cvat_pkg::CFG_MIN_W-1:0];
        cvat_pkg::CFG_MIN_Y:  min_y  <= cfg_data[cvat_pkg::CFG_MIN_W-1:0];
        cvat_pkg::CFG_MIN_Z:  min_z  <= cfg_data[cvat_pkg::CFG_MIN_W-1:0];
        cvat_pkg::CFG_SIZE_X: size_x <= cfg_data[cvat_pkg::CFG_SIZE_W-1:0];
        cvat_pkg::CFG_SIZE_Y: size_y <= cfg_data[cvat_pkg::CFG_SIZE_W-1:0];
        cvat_pkg::CFG_SIZE_Z: size_z <= cfg_data[cvat_pkg::CFG_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [cvat_pkg::WORLD_W-1:0] in_wx, in_wy, in_wz;
  logic [cvat_pkg::CELL_W-1:0]  in_cell;
  logic                         in_occ;
  logic [cvat_pkg::SLOT_W-1:0]  in_slot;
  logic [cvat_pkg::BASE_W-1:0]  in_base;

  assign in_wx   = in_data[cvat_pkg::TD_WX_LSB +: cvat_pkg::WORLD_W];
  assign in_wy   = in_data[cvat_pkg::TD_WY_LSB +: cvat_pkg::WORLD_W];
  assign in_wz   = in_data[cvat_pkg::TD_WZ_LSB +: cvat_pkg::WORLD_W];
  assign in_cell = in_data[cvat_pkg::TD_CELL_LSB +: cvat_pkg::CELL_W];
  assign in_occ  = in_data[cvat_pkg::TD_OCC_LSB];
  assign in_slot = in_data[cvat_pkg::TD_SLOT_LSB +: cvat_pkg::SLOT_W];
  assign in_base = in_data[cvat_pkg::TD_BASE_LSB +: cvat_pkg::BASE_W];

  assign st.is_translate = (in_mode == cvat_pkg::MODE_TRANSLATE);

  logic [cvat_pkg::TBL_CMP_W-1:0] in_cell_ext, in_slot_ext;
  logic in_cell_ok, in_slot_ok;

  assign in_cell_ext = cvat_pkg::TBL_CMP_W'(in_cell);
  assign in_slot_ext = cvat_pkg::TBL_CMP_W'(in_slot);
  assign in_cell_ok  = in_cell_ext < cvat_pkg::TBL_CMP_W'(cvat_pkg::MAP_CELLS);
  assign in_slot_ok  = in_slot_ext < cvat_pkg::TBL_CMP_W'(cvat_pkg::CHUNK_SLOTS);

  // Clearing pass counter over the occupancy table.
  logic [cvat_pkg::OCC_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign st.clr_last = (clr_addr == cvat_pkg::OCC_AW'(cvat_pkg::MAP_CELLS - 1));

  // Latched coordinate.
  logic [cvat_pkg::WORLD_W-1:0] wx, wy, wz;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      wx <= in_wx;
      wy <= in_wy;
      wz <= in_wz;
    end
  end

  // Floor division by a power of two is an arithmetic shift; the remainder
  // is the low bits, and the local offset is their concatenation.
  logic signed [cvat_pkg::CHUNK_COORD_W-1:0] chunk_x, chunk_y, chunk_z;
  logic signed [cvat_pkg::OFS_W-1:0]         ofs_x, ofs_y, ofs_z;
  logic [cvat_pkg::LOFF_W-1:0]               loff;
  logic inbox_x, inbox_y, inbox_z;

  assign chunk_x = wx[cvat_pkg::WORLD_W-1:cvat_pkg::CHUNK_BITS];
  assign chunk_y = wy[cvat_pkg::WORLD_W-1:cvat_pkg::CHUNK_BITS];
  assign chunk_z = wz[cvat_pkg::WORLD_W-1:cvat_pkg::CHUNK_BITS];
  assign ofs_x   = cvat_pkg::OFS_W'(chunk_x) - cvat_pkg::OFS_W'(min_x);
  assign ofs_y   = cvat_pkg::OFS_W'(chunk_y) - cvat_pkg::OFS_W'(min_y);
  assign ofs_z   = cvat_pkg::OFS_W'(chunk_z) - cvat_pkg::OFS_W'(min_z);
  assign loff    = {wz[cvat_pkg::CHUNK_BITS-1:0], wy[cvat_pkg::CHUNK_BITS-1:0],
                    wx[cvat_pkg::CHUNK_BITS-1:0]};

  assign inbox_x = !ofs_x[cvat_pkg::OFS_W-1] &&
                   (ofs_x[cvat_pkg::OFS_W-2:0] < (cvat_pkg::OFS_W-1)'(size_x));
  assign inbox_y = !ofs_y[cvat_pkg::OFS_W-1] &&
                   (ofs_y[cvat_pkg::OFS_W-2:0] < (cvat_pkg::OFS_W-1)'(size_y));
  assign inbox_z = !ofs_z[cvat_pkg::OFS_W-1] &&
                   (ofs_z[cvat_pkg::OFS_W-2:0] < (cvat_pkg::OFS_W-1)'(size_z));

  logic                          in_box;
  logic [cvat_pkg::BOX_W-1:0]    box_x, box_z;
  logic [cvat_pkg::PY_W-1:0]     prod_y;
  logic [cvat_pkg::SXY_W-1:0]    sxsy;
  logic [cvat_pkg::PZ_W-1:0]     prod_z;
  logic [cvat_pkg::CELL_SUM_W-1:0] cell_sum;
  logic                          cell_ok;

  always_ff @(posedge clk) begin
    if (cmd.calc1) begin
      in_box <= inbox_x && inbox_y && inbox_z;
      box_x  <= ofs_x[cvat_pkg::BOX_W-1:0];
      box_z  <= ofs_z[cvat_pkg::BOX_W-1:0];
      prod_y <= cvat_pkg::PY_W'(ofs_y[cvat_pkg::BOX_W-1:0]) * cvat_pkg::PY_W'(size_x);
      sxsy   <= cvat_pkg::SXY_W'(size_x) * cvat_pkg::SXY_W'(size_y);
    end
    if (cmd.calc2) begin
      prod_z <= cvat_pkg::PZ_W'(box_z) * cvat_pkg::PZ_W'(sxsy);
    end
    if (cmd.calc3) begin
      cell_ok <= in_box && (cell_sum < cvat_pkg::CELL_SUM_W'(cvat_pkg::MAP_CELLS));
    end
  end

  assign cell_sum = cvat_pkg::CELL_SUM_W'(box_x) + cvat_pkg::CELL_SUM_W'(prod_y) +
                    cvat_pkg::CELL_SUM_W'(prod_z);

  // Occupancy table: cleared by the sweep, loaded by mode 0.
  logic                        occ_we;
  logic [cvat_pkg::OCC_AW-1:0] occ_waddr;
  logic [cvat_pkg::OCC_W-1:0]  occ_wdata;
  logic [cvat_pkg::OCC_W-1:0]  occ_rdata;

  assign occ_we    = cmd.clr_step ||
                     (cmd.accept && (in_mode == cvat_pkg::MODE_OCC_WRITE) && in_cell_ok);
  assign occ_waddr = cmd.clr_step ? clr_addr : in_cell_ext[cvat_pkg::OCC_AW-1:0];
  assign occ_wdata = cmd.clr_step ? '0 : {in_occ, in_slot};

  cvat_ram #(
    .WIDTH (cvat_pkg::OCC_W),
    .DEPTH (cvat_pkg::MAP_CELLS)
  ) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .re    (cmd.calc3),
    .raddr (cell_sum[cvat_pkg::OCC_AW-1:0]),
    .rdata (occ_rdata)
  );

  logic                           occ_flag;
  logic [cvat_pkg::TBL_CMP_W-1:0] occ_slot_ext;
  logic                           occ_slot_ok;

  assign occ_flag     = occ_rdata[cvat_pkg::OCC_W-1];
  assign occ_slot_ext = cvat_pkg::TBL_CMP_W'(occ_rdata[cvat_pkg::SLOT_W-1:0]);
  assign occ_slot_ok  = occ_slot_ext < cvat_pkg::TBL_CMP_W'(cvat_pkg::CHUNK_SLOTS);

  // Chunk base table: loaded by mode 1, read at the occupied cell's slot.
  logic [cvat_pkg::BASE_W-1:0] base_rdata;

  cvat_ram #(
    .WIDTH (cvat_pkg::BASE_W),
    .DEPTH (cvat_pkg::CHUNK_SLOTS)
  ) u_base_ram (
    .clk   (clk),
    .we    (cmd.accept && (in_mode == cvat_pkg::MODE_BASE_WRITE) && in_slot_ok),
    .waddr (in_slot_ext[cvat_pkg::BASE_AW-1:0]),
    .wdata (in_base),
    .re    (cmd.occ),
    .raddr (occ_slot_ext[cvat_pkg::BASE_AW-1:0]),
    .rdata (base_rdata)
  );

  // Result registers.
  logic [cvat_pkg::STATUS_W-1:0] res_status;
  logic [cvat_pkg::IDX_W-1:0]    res_index;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_index  <= '0;
      res_status <= ((in_mode == cvat_pkg::MODE_OCC_WRITE) ||
                     (in_mode == cvat_pkg::MODE_BASE_WRITE)) ?
                    cvat_pkg::STATUS_WRITE_DONE : cvat_pkg::STATUS_OUTSIDE;
    end
    if (cmd.occ) begin
      priority if (!cell_ok) begin
        res_status <= cvat_pkg::STATUS_OUTSIDE;
      end else if (!occ_flag) begin
        res_status <= cvat_pkg::STATUS_EMPTY;
      end else if (!occ_slot_ok) begin
        res_status <= cvat_pkg::STATUS_OUTSIDE;
      end else begin
        res_status <= cvat_pkg::STATUS_RESOLVED;
      end
    end
    if (cmd.base) begin
      res_index <= (res_status == cvat_pkg::STATUS_RESOLVED) ?
                   (base_rdata + cvat_pkg::IDX_W'(loff)) : '0;
    end
    if (cmd.load_out) begin
      out_status <= res_status;
      out_data   <= cvat_pkg::OUT_TDATA_W'(res_index);
    end
  end

endmodule

FILE: rtl/chunked_voxel_address_translator.sv
// ----------------------------------------------------------------------------
// chunked_voxel_address_translator: world voxel to flat store index
// Loads an occupancy map and chunk base table, then translates coordinates.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A table write (mode 0 or 1) or an
// unused mode goes from the accept straight to the final output step, and
// a translate (mode 2) is stepped by the sequencer through the coordinate
// split, two registered multiply steps for the cell index, and the
// registered reads of the occupancy table and then the chunk base table.
// Results go through a one-entry output register, so the block can take
// the next item while a finished result is still waiting downstream; it
// only holds in its final step if that register is still full.
// After reset the occupancy table is swept clear, one cell per cycle, over
// all MAP_CELLS (4096) cells, while s_axis_tready stays low; configuration
// writes are taken during the sweep as at any other time.
module chunked_voxel_address_translator (
  input  logic                                 clk,
  input  logic                                 rst,

  // Configuration write port. Index 0..5: map_min_x, map_min_y, map_min_z,
  // map_size_x, map_size_y, map_size_z.
  input  logic                                 cfg_we,
  input  logic [cvat_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cvat_pkg::CFG_DATA_W-1:0]      cfg_data,

  // Input stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata from bit 0 up: world_x[23:0], world_y[47:24], world_z[71:48],
  // cell_number[83:72], cell_occupied[84], slot_number[94:85],
  // slot_base[122:95], zero fill[127:123].
  input  logic [cvat_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser from bit 0 up: mode[1:0].
  input  logic [cvat_pkg::MODE_W-1:0]          s_axis_tuser,

  // Result stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata from bit 0 up: voxel_index[27:0], zero fill[31:28].
  output logic [cvat_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // tuser from bit 0 up: status[1:0].
  output logic [cvat_pkg::STATUS_W-1:0]        m_axis_tuser
);

  // The sequencer and the datapath talk only through these two bundles.
  cvat_pkg::cvat_cmd_t  cmd;
  cvat_pkg::cvat_stat_t st;

  // The sequencer owns both handshakes and the output-valid flag; it issues one
  // command per cycle that advances the item a step, unless idle or stalled.
  cvat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds the map registers, both tables and the result
  // registers. Table writes land on the cycle of the input transfer, so a
  // following translate always sees them.
  cvat_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_data    (s_axis_tdata),
    .in_mode    (s_axis_tuser),
    .out_data   (m_axis_tdata),
    .out_status (m_axis_tuser),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

FILE: rtl/cvat_checker.sv
// ----------------------------------------------------------------------------
// cvat_checker: port-level checks of the address translator
// Watches the stream handshakes and the result encoding over time.
// ----------------------------------------------------------------------------
module cvat_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [cvat_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [cvat_pkg::STATUS_W-1:0]    m_axis_tuser
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed or dropped");

  // Only a resolved voxel carries a nonzero index.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != cvat_pkg::STATUS_RESOLVED) |->
      (m_axis_tdata == '0))
    else $error("nonzero index on an unresolved result");

  // The clearing pass keeps the input closed right after reset.
  assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input open during the clearing pass");

  // One item at a time: the input is closed in the cycle after an input transfer.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in flight");

endmodule

bind chunked_voxel_address_translator cvat_checker u_cvat_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
